// File: sv/lsfp_pkg.sv
package lsfp_pkg;

	localparam int MAX_LEDS   = 256;
	localparam int PREFIX_LEN = 3;
	localparam int BYTE_W     = 8;
	localparam int LED_CNT_W  = 9;
	localparam int CFG_IDX_W  = 2;

	localparam logic [BYTE_W-1:0]    CHECK_KEY = 8'h55;
	localparam logic [LED_CNT_W-1:0] LED_MAX_C = LED_CNT_W'(MAX_LEDS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREFIX_0 = 2'd0,
		REG_PREFIX_1 = 2'd1,
		REG_PREFIX_2 = 2'd2,
		REG_LED_CNT  = 2'd3
	} lsfp_reg_t;

	typedef enum logic [8:0] {
		PH_HUNT0 = 9'b000000001,
		PH_HUNT1 = 9'b000000010,
		PH_HUNT2 = 9'b000000100,
		PH_HIGH  = 9'b000001000,
		PH_LOW   = 9'b000010000,
		PH_CHECK = 9'b000100000,
		PH_RED   = 9'b001000000,
		PH_GREEN = 9'b010000000,
		PH_BLUE  = 9'b100000000
	} lsfp_phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0]    prefix_0;
		logic [BYTE_W-1:0]    prefix_1;
		logic [BYTE_W-1:0]    prefix_2;
		logic [LED_CNT_W-1:0] led_count;
	} lsfp_cfg_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] index;
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
		logic              last;
	} lsfp_pixel_t;

endpackage

// File: sv/led_serial_frame_parser_unit.sv
// Serial LED frame parser.
// Input channel: one received serial byte per word on rx_byte, taken at a
// clock edge with in_valid high and in_stall low. The parser hunts for the
// three prefix bytes, checks the header (high ^ low ^ 0x55) and then turns
// each red, green, blue triple into one pixel word.
// Output channel: pixel_index, pixel_red, pixel_green, pixel_blue and
// last_pixel, taken at an edge with out_valid high and out_stall low.
// last_pixel marks the final pixel of a frame of led_count pixels, at most 256.
// The blue byte passes the input register and the phase logic; the pixel
// is then held in the output register. Throughput: one byte per cycle
// when the output does not stall, set by the single input and output registers.
// A stalled output holds its word; the byte waiting in the input register
// then holds and in_stall rises, so at most two words sit in flight.
// Reset (arst_n low) empties both registers, returns the parser to hunting
// and loads the default prefix "Ada" and a count of 95.
// Configuration: cfg_write with cfg_index 0..2 sets the prefix bytes and 3
// sets led_count; write only while no word is in flight.
module led_serial_frame_parser_unit
	import lsfp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LED_CNT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    pixel_index,
	output logic [BYTE_W-1:0]    pixel_red,
	output logic [BYTE_W-1:0]    pixel_green,
	output logic [BYTE_W-1:0]    pixel_blue,
	output logic                 last_pixel
);

	lsfp_cfg_t         cfg_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              advance;
	lsfp_pixel_t       pixel;
	logic              out_valid_q;
	lsfp_pixel_t       out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prefix_0  <= 8'd65;
			cfg_q.prefix_1  <= 8'd100;
			cfg_q.prefix_2  <= 8'd97;
			cfg_q.led_count <= 9'd95;
		end else if (cfg_write) begin
			unique case (lsfp_reg_t'(cfg_index))
				REG_PREFIX_0: cfg_q.prefix_0  <= cfg_data[BYTE_W-1:0];
				REG_PREFIX_1: cfg_q.prefix_1  <= cfg_data[BYTE_W-1:0];
				REG_PREFIX_2: cfg_q.prefix_2  <= cfg_data[BYTE_W-1:0];
				REG_LED_CNT:  cfg_q.led_count <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	lsfp_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.pixel   (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && pixel.valid)
			out_q <= pixel;
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = out_q.index;
	assign pixel_red   = out_q.red;
	assign pixel_green = out_q.green;
	assign pixel_blue  = out_q.blue;
	assign last_pixel  = out_q.last;

endmodule

// File: sv/lsfp_parse_core.sv
module lsfp_parse_core
	import lsfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] rx_byte,
	input  lsfp_cfg_t         cfg,
	output lsfp_pixel_t       pixel
);

	lsfp_phase_t          phase_q, phase_d;
	logic [BYTE_W-1:0]    high_q, high_d;
	logic [BYTE_W-1:0]    low_q, low_d;
	logic [BYTE_W-1:0]    count_q, count_d;
	logic [BYTE_W-1:0]    red_q, red_d;
	logic [BYTE_W-1:0]    green_q, green_d;
	logic [LED_CNT_W-1:0] frame_len;
	logic                 is_last;

	assign frame_len = (cfg.led_count > LED_MAX_C) ? LED_MAX_C : cfg.led_count;
	assign is_last   = ({1'b0, count_q} + LED_CNT_W'(1)) >= frame_len;

	always_comb begin
		phase_d     = phase_q;
		high_d      = high_q;
		low_d       = low_q;
		count_d     = count_q;
		red_d       = red_q;
		green_d     = green_q;
		pixel.valid = 1'b0;
		pixel.index = count_q;
		pixel.red   = red_q;
		pixel.green = green_q;
		pixel.blue  = rx_byte;
		pixel.last  = is_last;
		unique case (phase_q)
			PH_HUNT1: begin
				if (rx_byte != cfg.prefix_1)
					phase_d = PH_HUNT0;
				else if (PREFIX_LEN > 2)
					phase_d = PH_HUNT2;
				else
					phase_d = PH_HIGH;
			end
			PH_HUNT2: begin
				phase_d = (rx_byte == cfg.prefix_2) ? PH_HIGH : PH_HUNT0;
			end
			PH_HIGH: begin
				high_d  = rx_byte;
				phase_d = PH_LOW;
			end
			PH_LOW: begin
				low_d   = rx_byte;
				phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				if (rx_byte != (high_q ^ low_q ^ CHECK_KEY) || frame_len == '0) begin
					phase_d = PH_HUNT0;
				end else begin
					count_d = '0;
					phase_d = PH_RED;
				end
			end
			PH_RED: begin
				red_d   = rx_byte;
				phase_d = PH_GREEN;
			end
			PH_GREEN: begin
				green_d = rx_byte;
				phase_d = PH_BLUE;
			end
			PH_BLUE: begin
				pixel.valid = 1'b1;
				if (is_last) begin
					count_d = '0;
					phase_d = PH_HUNT0;
				end else begin
					count_d = count_q + BYTE_W'(1);
					phase_d = PH_RED;
				end
			end
			default: begin
				if (rx_byte != cfg.prefix_0)
					phase_d = PH_HUNT0;
				else if (PREFIX_LEN > 1)
					phase_d = PH_HUNT1;
				else
					phase_d = PH_HIGH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			high_q  <= '0;
			low_q   <= '0;
			count_q <= '0;
			red_q   <= '0;
			green_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			high_q  <= high_d;
			low_q   <= low_d;
			count_q <= count_d;
			red_q   <= red_d;
			green_q <= green_d;
		end
	end

endmodule
